>>> rtl/fdakf_pkg.sv
`default_nettype none

package fdakf_pkg;

  localparam int MASK_W      = 32;
  localparam int IDX_W       = 6;
  localparam int DEP_INDEX_W = 5;
  localparam int MAX_ATTRS   = 32;
  localparam int ATTR_CNT_W  = 6;
  localparam int OUT_DATA_W  = 72;

  // target value that matches no cell, used on repeat passes
  localparam logic [IDX_W-1:0] TARGET_NONE = {IDX_W{1'b1}};

  localparam logic KIND_CLOSURE = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  target;
    logic              grew;
    logic [MASK_W-1:0] left;
    logic [MASK_W-1:0] closure;
  } fd_token_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] left;
    logic [MASK_W-1:0] right;
  } fd_load_t;

endpackage

`default_nettype wire

>>> rtl/fdakf_cell.sv
`default_nettype none

module fdakf_cell
  import fdakf_pkg::*;
#(
  parameter int J = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fd_load_t         load,
  input  wire logic [IDX_W-1:0] dep_count,
  input  wire fd_token_t        tok_in,
  output fd_token_t             tok_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(J);

  logic [MASK_W-1:0] left_r;
  logic [MASK_W-1:0] right_r;
  fd_token_t         tok_r;
  fd_token_t         tok_nxt;
  logic              active;

  assign active = (MY_IDX < dep_count);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.target == MY_IDX) begin
      // seed: this is the dependency whose closure is wanted
      tok_nxt.closure = tok_in.closure | left_r | right_r;
      tok_nxt.left    = left_r;
    end else if (active && ((left_r & ~tok_in.closure) == '0) &&
                 ((right_r & ~tok_in.closure) != '0)) begin
      tok_nxt.closure = tok_in.closure | right_r;
      tok_nxt.grew    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.en && (load.idx == MY_IDX)) begin
      left_r  <= load.left;
      right_r <= load.right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.target  <= tok_nxt.target;
    tok_r.grew    <= tok_nxt.grew;
    tok_r.left    <= tok_nxt.left;
    tok_r.closure <= tok_nxt.closure;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

>>> rtl/fd_attribute_closure_key_finder.sv
// loading: one dependency transaction per cycle, in_tready high only while loading
// run: per dependency a closure token walks the cell chain for at least two passes,
//   repeating while the closure grows; output stalls hold the run
// final record follows the last closure record; then loading resumes
// reset (rst_n low, synchronous): counters, flags and state cleared, attribute
//   count set to 32; dependency table contents undefined until loaded
`default_nettype none

module fd_attribute_closure_key_finder
  import fdakf_pkg::*;
#(
  parameter int MAX_FDS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [ATTR_CNT_W-1:0] cfg_wr_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // left_mask, right_mask
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // dep_index, closure_mask, is_key,
                                                 // primary_key_mask, table_overflow, pad
  output logic                       out_tuser,  // record_kind
  output logic                       out_tlast
);

  localparam logic [IDX_W-1:0] FD_LIMIT = IDX_W'(MAX_FDS);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_INJECT = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_FINAL  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [ATTR_CNT_W-1:0] attr_cnt_r;
  logic [IDX_W-1:0]      count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  first_r, first_nxt;
  logic                  found_r, found_nxt;
  logic [MASK_W-1:0]     best_r, best_nxt;
  logic [ATTR_CNT_W-1:0] best_sz_r, best_sz_nxt;
  logic [MASK_W-1:0]     res_closure_r, res_closure_nxt;
  logic [MASK_W-1:0]     res_left_r, res_left_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [ATTR_CNT_W-1:0] attr_n;
  logic [MASK_W-1:0]     all_mask;
  logic                  in_acc;
  logic                  out_free;
  logic [ATTR_CNT_W-1:0] left_sz;
  logic                  is_key;

  fd_load_t              load;
  fd_token_t             tok_head;
  fd_token_t             tok [MAX_FDS+1];

  always_comb begin
    attr_n = attr_cnt_r;
    if (attr_n == '0) attr_n = ATTR_CNT_W'(1);
    if (attr_n > ATTR_CNT_W'(MAX_ATTRS)) attr_n = ATTR_CNT_W'(MAX_ATTRS);
    if (attr_n > ATTR_CNT_W'(MASK_W)) attr_n = ATTR_CNT_W'(MASK_W);
    if (attr_n == ATTR_CNT_W'(MASK_W)) begin
      all_mask = '1;
    end else begin
      all_mask = (MASK_W'(1) << attr_n[4:0]) - MASK_W'(1);
    end
  end

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign left_sz   = ATTR_CNT_W'($countones(res_left_r));
  assign is_key    = (res_closure_r == all_mask);

  assign tok[0] = tok_head;

  genvar g;
  generate
    for (g = 0; g < MAX_FDS; g++) begin : g_cell
      fdakf_cell #(.J(g)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .dep_count (count_r),
        .tok_in    (tok[g]),
        .tok_out   (tok[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    idx_nxt         = idx_r;
    first_nxt       = first_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_sz_nxt     = best_sz_r;
    res_closure_nxt = res_closure_r;
    res_left_nxt    = res_left_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_kind_nxt    = out_kind_r;
    out_last_nxt    = out_last_r;

    load.en    = 1'b0;
    load.idx   = count_r;
    load.left  = in_tdata[31:0] & all_mask;
    load.right = in_tdata[63:32] & all_mask;

    tok_head = '0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < FD_LIMIT) begin
            load.en   = 1'b1;
            count_nxt = count_r + IDX_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            idx_nxt     = '0;
            found_nxt   = 1'b0;
            best_nxt    = '0;
            best_sz_nxt = '0;
            state_nxt   = ST_INJECT;
          end
        end
      end
      ST_INJECT: begin
        if (idx_r >= count_r) begin
          state_nxt = ST_FINAL;
        end else begin
          tok_head.valid  = 1'b1;
          tok_head.target = idx_r;
          first_nxt       = 1'b1;
          state_nxt       = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tok[MAX_FDS].valid) begin
          if (first_r || tok[MAX_FDS].grew) begin
            tok_head.valid   = 1'b1;
            tok_head.target  = TARGET_NONE;
            tok_head.left    = tok[MAX_FDS].left;
            tok_head.closure = tok[MAX_FDS].closure;
            first_nxt        = 1'b0;
          end else begin
            res_closure_nxt = tok[MAX_FDS].closure;
            res_left_nxt    = tok[MAX_FDS].left;
            state_nxt       = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CLOSURE;
          out_last_nxt  = 1'b0;
          out_data_nxt  = {1'b0, 1'b0, {MASK_W{1'b0}}, is_key, res_closure_r,
                           idx_r[DEP_INDEX_W-1:0]};
          if (is_key && (!found_r || (left_sz < best_sz_r))) begin
            found_nxt   = 1'b1;
            best_nxt    = res_left_r;
            best_sz_nxt = left_sz;
          end
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_INJECT;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FINAL;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {1'b0, ovf_r, (found_r ? best_r : all_mask), found_r,
                           {MASK_W{1'b0}}, {DEP_INDEX_W{1'b0}}};
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      attr_cnt_r  <= ATTR_CNT_W'(32);
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      first_r     <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_sz_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) attr_cnt_r <= cfg_wr_data;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      first_r     <= first_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      best_sz_r   <= best_sz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_closure_r <= res_closure_nxt;
    res_left_r    <= res_left_nxt;
    out_data_r    <= out_data_nxt;
    out_kind_r    <= out_kind_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> test/fd_attribute_closure_key_finder_tb.sv
`default_nettype none

module fd_attribute_closure_key_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdakf_pkg::*;

  localparam int MAX_FDS  = 32;
  localparam int N_PHASES = 8;
  localparam int LIMIT    = 2_000_000;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } dep_item_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic [31:0] closure;
    logic        key;
    logic [31:0] pk;
    logic        ovf;
    logic        last;
  } key_record_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [ATTR_CNT_W-1:0] cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;   // left_mask, right_mask
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // dep_index, closure_mask, is_key,
                                          // primary_key_mask, table_overflow, pad
  logic                  out_tuser;       // record_kind
  logic                  out_tlast;

  dep_item_t   pending_deps[$];
  key_record_t expected_records[$];
  logic [31:0] left_tab[MAX_FDS];
  logic [31:0] right_tab[MAX_FDS];
  int          stored_deps = 0;
  logic        table_overflowed = 1'b0;
  logic [5:0]  attr_count_reg = 6'd32;
  int          queued_total = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          cycles = 0;

  fd_attribute_closure_key_finder #(
    .MAX_FDS(MAX_FDS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] attr_span(logic [5:0] cnt);
    int         m;
    logic [63:0] one;
    m = cnt;
    if (m == 0) m = 1;
    if (m > MAX_ATTRS) m = MAX_ATTRS;
    if (m > 32) m = 32;
    one = 64'd1;
    return 32'((one << m) - 64'd1);
  endfunction

  // store one dependency; on the final one, work out every closure record
  // and the primary key record
  function automatic void absorb_dependency(dep_item_t d);
    logic [31:0] span;
    logic [31:0] closure;
    logic [31:0] applied;
    logic [31:0] best;
    int          best_size;
    logic        found;
    logic        grew;
    key_record_t rec;
    span = attr_span(attr_count_reg);
    if (stored_deps < MAX_FDS) begin
      left_tab[stored_deps]  = d.left & span;
      right_tab[stored_deps] = d.right & span;
      stored_deps++;
    end else begin
      table_overflowed = 1'b1;
    end
    if (!d.last) return;
    found = 1'b0;
    best = '0;
    best_size = 0;
    for (int i = 0; i < stored_deps; i++) begin
      closure = (left_tab[i] | right_tab[i]) & span;
      applied = 32'd1 << i;
      grew = 1'b1;
      while (grew) begin
        grew = 1'b0;
        for (int j = 0; j < stored_deps; j++) begin
          if (!applied[j] && (left_tab[j] & ~closure) == '0) begin
            applied[j] = 1'b1;
            if ((right_tab[j] & ~closure) != '0) begin
              closure |= right_tab[j];
              grew = 1'b1;
            end
          end
        end
      end
      rec.kind    = KIND_CLOSURE;
      rec.idx     = 5'(i);
      rec.closure = closure;
      rec.key     = (closure == span);
      rec.pk      = '0;
      rec.ovf     = 1'b0;
      rec.last    = 1'b0;
      if (rec.key && (!found || $countones(left_tab[i]) < best_size)) begin
        best = left_tab[i];
        best_size = $countones(left_tab[i]);
        found = 1'b1;
      end
      expected_records = {expected_records, rec};
    end
    rec.kind    = KIND_FINAL;
    rec.idx     = '0;
    rec.closure = '0;
    rec.key     = found;
    rec.pk      = found ? best : span;
    rec.ovf     = table_overflowed;
    rec.last    = 1'b1;
    expected_records = {expected_records, rec};
    stored_deps = 0;
    table_overflowed = 1'b0;
  endfunction

  function automatic void queue_dep(logic [31:0] l, logic [31:0] r, logic last);
    dep_item_t d;
    d.left = l;
    d.right = r;
    d.last = last;
    pending_deps = {pending_deps, d};
    queued_total++;
  endfunction

  // mostly sparse left sides with chained right sides so closures grow
  // over several passes; noisy tables use raw 32-bit masks
  function automatic void queue_table(int size, logic noisy);
    logic [31:0] span;
    logic [31:0] lefts[40];
    logic [31:0] l;
    logic [31:0] r;
    int          n;
    int          k;
    span = attr_span(attr_count_reg);
    n = $countones(span);
    for (int i = 0; i < size; i++) begin
      lefts[i] = '0;
      k = $urandom_range(0, 3);
      for (int t = 0; t < k; t++) lefts[i] |= 32'd1 << $urandom_range(0, n - 1);
    end
    for (int i = 0; i < size; i++) begin
      if (noisy) begin
        l = $urandom;
        r = $urandom;
      end else begin
        l = lefts[i];
        r = $urandom & $urandom & span;
        if (i + 1 < size && $urandom_range(0, 1) == 0) r |= lefts[i + 1];
        if ($urandom_range(0, 9) == 0) r |= span;
        if ($urandom_range(0, 3) == 0) begin
          l |= $urandom & ~span;
          r |= $urandom & ~span;
        end
      end
      queue_dep(l, r, i == size - 1);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    dep_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_dependency({in_tdata[31:0], in_tdata[63:32], in_tlast});
      if (!in_tvalid || in_tready) begin
        if (pending_deps.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = pending_deps.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.right, nxt.left};
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_proc
    key_record_t exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_records.size() == 0) begin
        $error("result transaction with no record expected");
        errors++;
      end else begin
        exp_rec = expected_records.pop_front();
        check_field("record_kind", exp_rec.kind, out_tuser);
        check_field("dep_index", exp_rec.idx, out_tdata[4:0]);
        check_field("closure_mask", exp_rec.closure, out_tdata[36:5]);
        check_field("is_key", exp_rec.key, out_tdata[37]);
        check_field("primary_key_mask", exp_rec.pk, out_tdata[69:38]);
        check_field("table_overflow", exp_rec.ovf, out_tdata[70]);
        check_field("last_record", exp_rec.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("fd_attribute_closure_key_finder: mismatch");
      $finish;
    end
  end

  initial begin
    int   target;
    int   r;
    logic [5:0] cfg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 3) begin
        gap_pct = 31;
        stall_pct = 62;
      end else if (p < 6) begin
        gap_pct = 62;
        stall_pct = 31;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      case (p)
        0: cfg = 6'd32;
        1: cfg = 6'd1;
        2: cfg = 6'd0;
        3: cfg = 6'd63;
        4: cfg = 6'd33;
        5: cfg = 6'd7;
        6: cfg = 6'd20;
        default: cfg = 6'($urandom_range(2, 31));
      endcase
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cfg;
      attr_count_reg = cfg;
      @(posedge clk);
      cfg_wr_en <= 1'b0;

      if (p == 0) begin
        queue_dep(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_dep(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        queue_dep(32'h0000_0000, 32'h0000_0000, 1'b1);
        // chain of single-attribute left sides where only the first one is a key
        queue_dep(32'h0000_0001, 32'h0000_0002, 1'b0);
        queue_dep(32'h0000_0002, 32'h0000_0004, 1'b0);
        queue_dep(32'h0000_0004, 32'hFFFF_FFF8, 1'b1);
        // smaller key found after a larger one
        queue_dep(32'h0000_0003, 32'hFFFF_FFFC, 1'b0);
        queue_dep(32'h0000_0001, 32'h0000_0002, 1'b1);
        queue_dep(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_dep(32'h0000_0005, 32'h0000_000A, 1'b0);
        queue_dep(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        // left side never covered
        queue_dep(32'h0000_0006, 32'h0000_0001, 1'b0);
        queue_dep(32'h0000_0001, 32'h0000_0008, 1'b1);
      end
      case (p)
        1: queue_table(32, 1'b0);
        3: queue_table(33, 1'b0);
        5: queue_table(36, 1'b0);
        default: ;
      endcase
      target = queued_total + 16;
      while (queued_total < target) begin
        r = $urandom_range(0, 9);
        if (r < 7) queue_table($urandom_range(1, 6), $urandom_range(0, 3) == 0);
        else if (r < 9) queue_table($urandom_range(7, 31), $urandom_range(0, 3) == 0);
        else queue_table($urandom_range(32, 35), 1'b0);
      end

      do @(negedge clk);
      while (pending_deps.size() != 0 || in_tvalid || expected_records.size() != 0);
      repeat (40) @(negedge clk);
    end
    repeat (1100) @(negedge clk);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("fd_attribute_closure_key_finder: match");
    end else begin
      $display("fd_attribute_closure_key_finder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
